>>> sv/psl_pkg.sv
// Package for the pairing / standby LED controller.
// Holds the mode encoding, register defaults, register indexes and the beat structs.
// No dependencies.
package psl_pkg;

  // Connection state machine, one-hot
  typedef enum logic [5:0] {
    M_INIT  = 6'b000001,
    M_DISC  = 6'b000010,
    M_PAIR  = 6'b000100,
    M_CHECK = 6'b001000,
    M_FAIL  = 6'b010000,
    M_CONN  = 6'b100000
  } mode_t;

  // Mode codes as seen on the result channel
  localparam logic [2:0] MODE_INIT  = 3'd0;
  localparam logic [2:0] MODE_DISC  = 3'd1;
  localparam logic [2:0] MODE_PAIR  = 3'd2;
  localparam logic [2:0] MODE_CHECK = 3'd3;
  localparam logic [2:0] MODE_FAIL  = 3'd4;
  localparam logic [2:0] MODE_CONN  = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_STANDBY_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_ACK_WINDOW      = 3'd1;
  localparam logic [2:0] REG_BLINK_INTERVAL  = 3'd2;
  localparam logic [2:0] REG_ATTEMPT_LIMIT   = 3'd3;
  localparam logic [2:0] REG_PAIRING_COLOR   = 3'd4;
  localparam logic [2:0] REG_CONNECTED_COLOR = 3'd5;
  localparam logic [2:0] REG_STANDBY_COLOR   = 3'd6;

  // Register defaults
  localparam logic [31:0] STANDBY_TIMEOUT_DEF = 32'd60000;
  localparam logic [31:0] ACK_WINDOW_DEF      = 32'd10000;
  localparam logic [15:0] BLINK_INTERVAL_DEF  = 16'd250;
  localparam logic [7:0]  ATTEMPT_LIMIT_DEF   = 8'd10;
  localparam logic [23:0] PAIRING_COLOR_DEF   = 24'hFDF8E2;
  localparam logic [23:0] CONNECTED_COLOR_DEF = 24'h0FFF0F;
  localparam logic [23:0] STANDBY_COLOR_DEF   = 24'h0F0A00;

  localparam logic [7:0]  ATTEMPT_MAX = 8'hFF;

  typedef struct packed {
    logic        audio_seen;
    logic        button_down;
    logic        pin_request;
    logic        link_up;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [23:0] led_color;
    logic        confirm_pin;
    logic        relay_on;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      M_DISC:  c = MODE_DISC;
      M_PAIR:  c = MODE_PAIR;
      M_CHECK: c = MODE_CHECK;
      M_FAIL:  c = MODE_FAIL;
      M_CONN:  c = MODE_CONN;
      default: c = MODE_INIT;
    endcase
    return c;
  endfunction

endpackage

>>> sv/psl_core.sv
// Tick engine: config registers, controller state and the single-pass next-state logic.
// Depends on psl_pkg.
module psl_core import psl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        fire,
  input  item_t       item,
  output result_t     res
);

  logic [31:0] standby_timeout_r, ack_window_r;
  logic [15:0] blink_interval_r;
  logic [7:0]  attempt_limit_r;
  logic [23:0] pairing_color_r, connected_color_r, standby_color_r;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  attempt_r, attempt_nxt;
  logic [31:0] button_time_r, button_time_nxt;
  logic [31:0] last_play_r, last_play_nxt;
  logic [31:0] last_blink_r, last_blink_nxt;
  logic        ack_r, ack_nxt;
  logic        standby_r, standby_nxt;
  logic [23:0] steady_r, steady_nxt;
  logic [23:0] blink_r, blink_nxt;
  logic        phase_r, phase_nxt;
  logic [23:0] shown_r, shown_nxt;
  logic        relay_r, relay_nxt;
  logic        confirm;
  logic        over;
  logic [31:0] ack_age, idle_age, blink_age;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      standby_timeout_r <= STANDBY_TIMEOUT_DEF;
      ack_window_r      <= ACK_WINDOW_DEF;
      blink_interval_r  <= BLINK_INTERVAL_DEF;
      attempt_limit_r   <= ATTEMPT_LIMIT_DEF;
      pairing_color_r   <= PAIRING_COLOR_DEF;
      connected_color_r <= CONNECTED_COLOR_DEF;
      standby_color_r   <= STANDBY_COLOR_DEF;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STANDBY_TIMEOUT: standby_timeout_r <= cfg_wdata;
        REG_ACK_WINDOW:      ack_window_r      <= cfg_wdata;
        REG_BLINK_INTERVAL:  blink_interval_r  <= cfg_wdata[15:0];
        REG_ATTEMPT_LIMIT:   attempt_limit_r   <= cfg_wdata[7:0];
        REG_PAIRING_COLOR:   pairing_color_r   <= cfg_wdata[23:0];
        REG_CONNECTED_COLOR: connected_color_r <= cfg_wdata[23:0];
        REG_STANDBY_COLOR:   standby_color_r   <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    attempt_nxt     = attempt_r;
    button_time_nxt = button_time_r;
    last_play_nxt   = item.audio_seen ? item.now_ms : last_play_r;
    relay_nxt       = relay_r;
    shown_nxt       = shown_r;
    confirm         = 1'b0;
    over            = 1'b0;

    case (mode_r)
      M_DISC: begin
        relay_nxt = 1'b0;
        if (item.pin_request) mode_nxt = M_PAIR;
        if (item.link_up) begin
          mode_nxt    = M_CONN;
          attempt_nxt = '0;
        end
      end
      M_PAIR: begin
        if (ack_r) begin
          confirm  = 1'b1;
          mode_nxt = M_CHECK;
        end
        if (!item.pin_request) begin
          button_time_nxt = '0;
          mode_nxt        = M_DISC;
        end
      end
      M_CHECK: begin
        if (item.link_up) begin
          mode_nxt      = M_CONN;
          attempt_nxt   = '0;
          last_play_nxt = item.now_ms;
        end
        // limit check sees the count after a link-up clear
        over = attempt_nxt > attempt_limit_r;
        if (attempt_nxt != ATTEMPT_MAX) attempt_nxt = attempt_nxt + 8'd1;
        if (over || !item.pin_request) mode_nxt = M_FAIL;
      end
      M_FAIL: begin
        button_time_nxt = '0;
        mode_nxt        = M_DISC;
      end
      M_CONN: begin
        relay_nxt = !standby_r;
        if (!item.link_up) begin
          mode_nxt        = M_DISC;
          button_time_nxt = '0;
        end
      end
      default: begin
        shown_nxt = '0;
        mode_nxt  = M_DISC;
      end
    endcase

    if (item.button_down) begin
      button_time_nxt = item.now_ms;
      last_play_nxt   = item.now_ms;
    end

    ack_age     = item.now_ms - button_time_nxt;
    idle_age    = item.now_ms - last_play_nxt;
    ack_nxt     = (ack_age < ack_window_r) && (button_time_nxt != '0);
    standby_nxt = !(idle_age < standby_timeout_r);

    steady_nxt = steady_r;
    blink_nxt  = blink_r;
    if (ack_nxt) begin
      steady_nxt = '0;
      blink_nxt  = pairing_color_r;
    end
    if (!ack_nxt && mode_nxt == M_DISC) begin
      steady_nxt = '0;
      blink_nxt  = '0;
    end
    if (mode_nxt == M_CONN) begin
      steady_nxt = connected_color_r;
      blink_nxt  = '0;
    end
    if (mode_nxt == M_PAIR && !ack_nxt) begin
      steady_nxt = '0;
      blink_nxt  = pairing_color_r;
    end
    if (mode_nxt == M_CONN && standby_nxt) begin
      steady_nxt = standby_color_r;
      blink_nxt  = '0;
    end

    blink_age      = item.now_ms - last_blink_r;
    last_blink_nxt = last_blink_r;
    phase_nxt      = phase_r;
    if (blink_age > {16'd0, blink_interval_r}) begin
      last_blink_nxt = item.now_ms;
      if (blink_nxt != '0) begin
        shown_nxt = phase_r ? blink_nxt : 24'd0;
        phase_nxt = !phase_r;
      end else begin
        phase_nxt = 1'b1;
      end
    end
    if (steady_nxt != '0) shown_nxt = steady_nxt;
    if (steady_nxt == '0 && blink_nxt == '0) shown_nxt = '0;

    res.relay_on    = relay_nxt;
    res.confirm_pin = confirm;
    res.led_color   = shown_nxt;
    res.mode        = mode_code(mode_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= M_INIT;
      attempt_r     <= '0;
      button_time_r <= '0;
      last_play_r   <= '0;
      last_blink_r  <= '0;
      ack_r         <= 1'b0;
      standby_r     <= 1'b0;
      steady_r      <= '0;
      blink_r       <= '0;
      phase_r       <= 1'b0;
      shown_r       <= '0;
      relay_r       <= 1'b0;
    end else if (fire) begin
      mode_r        <= mode_nxt;
      attempt_r     <= attempt_nxt;
      button_time_r <= button_time_nxt;
      last_play_r   <= last_play_nxt;
      last_blink_r  <= last_blink_nxt;
      ack_r         <= ack_nxt;
      standby_r     <= standby_nxt;
      steady_r      <= steady_nxt;
      blink_r       <= blink_nxt;
      phase_r       <= phase_nxt;
      shown_r       <= shown_nxt;
      relay_r       <= relay_nxt;
    end
  end

endmodule

>>> sv/pairing_standby_led_controller_unit.sv
// Pairing / standby LED controller, top level: stream ports, input and result registers.
// Depends on psl_pkg and psl_core.
//
// One tick beat in per control pass on in_*, one result beat out on out_* per tick.
// Input beat: timestamp, link and pin status, button and audio flags. Result beat:
// relay level, pin-confirm pulse, LED colour and the mode after the tick.
// Configuration registers are written through cfg_we / cfg_addr / cfg_wdata, one per
// clock, by the user only while no tick is in flight (unchecked); defaults at reset.
// An accepted beat is registered in the input register, processed once the result
// register is free, then held in the result register and shown on out_* from then on.
// Throughput: one tick per clock while out_tready is high; the tick logic is a single
// pass between input and result registers; the controller state updates on that pass.
// Stall: while out_tready is low the result register holds, the pending tick waits
// in the input register, and in_tready drops once that register is occupied.
// Reset (rst_n low, synchronous): both registers empty, state machine back to init,
// relay off, LEDs dark, configuration back to defaults.
module pairing_standby_led_controller_unit import psl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // now_ms[31:0], link_up, pin_request, button_down,
                                  // audio_seen, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // relay_on, confirm_pin, led_color[23:0], mode[2:0],
                                  // zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  item_t   in_r;
  logic    in_valid_r, in_valid_nxt;
  result_t out_r, res;
  logic    out_valid_r, out_valid_nxt;
  logic    fire, in_take;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign in_take   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_take || (in_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_r <= in_tdata[35:0];
    if (fire)    out_r <= res;
  end

  psl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_r),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_r};

endmodule

>>> sv/psl_checker.sv
// Port-level checks for the pairing / standby LED controller, bound to the top level.
// Depends on psl_pkg and pairing_standby_led_controller_unit.
module psl_checker import psl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic [2:0] mode;
  assign mode = out_tdata[28:26];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a confirm pulse leaves pairing for checking, or drops back if the pin went away
  a_confirm_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> mode == MODE_CHECK || mode == MODE_DISC)
    else $error("confirm pulse outside pairing exit");

  // relay is only driven while connected, or on the tick that drops the link
  a_relay_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> mode == MODE_CONN || mode == MODE_DISC)
    else $error("relay on outside connected state");

  // reported mode is a real state, pad bits zero
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> mode <= MODE_CONN && out_tdata[31:29] == 3'd0)
    else $error("bad mode code or pad bits");

endmodule

bind pairing_standby_led_controller_unit psl_checker u_psl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
